// ===== rtl/fractal_value_noise_2d_macros.svh =====
// ----------------------------------------------------------------------------
// fractal value noise assertion macros
// concurrent assertion helpers, empty when synthesising
// ----------------------------------------------------------------------------
`ifndef FRACTAL_VALUE_NOISE_2D_MACROS_SVH
`define FRACTAL_VALUE_NOISE_2D_MACROS_SVH
`ifndef SYNTHESIS
`define FVN_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define FVN_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define FVN_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define FVN_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/fvn2d_pkg.sv =====
// ----------------------------------------------------------------------------
// fractal value noise package
// register indexes, reset values and hash constants
// ----------------------------------------------------------------------------
package fvn2d_pkg;

   localparam int MAX_OCTAVES_DEF   = 16;
   localparam int FRACTION_BITS_DEF = 16;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_PERSISTENCE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OCTAVE_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_FREQ     = 2'd2;

   localparam logic [16:0] PERSISTENCE_RST  = 17'd32768;
   localparam logic [4:0]  OCTAVE_COUNT_RST = 5'd4;
   localparam logic [31:0] INV_FREQ_RST     = 32'd65536;

   localparam logic [31:0] HASH_C1   = 32'd15731;
   localparam logic [31:0] HASH_C2   = 32'd789221;
   localparam logic [31:0] HASH_C3   = 32'd1376312589;
   localparam logic [31:0] HASH_MASK = 32'h7fff_ffff;
   localparam logic [31:0] HASH_ONE  = 32'd1073741824;

   localparam logic [16:0] AMP_START = 17'd65536;
   localparam logic [16:0] AMP_MAX   = 17'd131071;
   localparam int          OUT_MAX   = 1048576;
   localparam int          SUM_FRAC  = 50;

endpackage

// ===== rtl/fractal_value_noise_2d.sv =====
// ----------------------------------------------------------------------------
// fractal value noise 2d
// octave-summed value noise over one shared multiplier and a sequencer
// ----------------------------------------------------------------------------
// a point is scaled, then each octave is hashed and interpolated, then the result goes to the
// output register, which waits while an earlier result is still stalled
// a new point is accepted only in idle, so one point is in flight at a time; the shared multiplier
// runs three steps per lattice hash, sixteen hashes per octave
// reset clears the sequencer and output valid and loads the register defaults
module fractal_value_noise_2d #(
   parameter int MAX_OCTAVES   = fvn2d_pkg::MAX_OCTAVES_DEF,
   parameter int FRACTION_BITS = fvn2d_pkg::FRACTION_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [31:0]               req_coord_x,
   input  logic signed [31:0]               req_coord_y,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [21:0]               rsp_noise_value,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [fvn2d_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [31:0]                      csr_wdata
);

   `include "fractal_value_noise_2d_macros.svh"

   localparam int F   = FRACTION_BITS;
   localparam int AW  = 40;
   localparam int BW  = 34;
   localparam int PW  = AW + BW;
   localparam int VW  = 40;
   localparam int SH  = fvn2d_pkg::SUM_FRAC - F;
   localparam logic signed [PW-1:0] LERP_RND = PW'((64'd1 << F) - 64'd1);
   localparam logic signed [63:0]   SUM_RND  = 64'((64'd1 << SH) - 64'd1);

   typedef enum logic [4:0] {
      ST_IDLE, ST_SCALE_X, ST_SCALE_Y, ST_SCALE_END, ST_OCT,
      ST_H0, ST_H1, ST_H2, ST_H3, ST_HACC,
      ST_L0, ST_L1, ST_L2, ST_L3, ST_L4, ST_L5, ST_L6, ST_L7, ST_FIN
   } state_type;

   state_type               state_ff;
   logic [16:0]             pers_ff;
   logic [4:0]              octs_ff;
   logic [31:0]             invf_ff;
   logic signed [31:0]      cx_ff, cy_ff;
   logic signed [63:0]      px_ff, py_ff;
   logic [31:0]             lx_ff, ly_ff;
   logic signed [F:0]       fx_ff, fy_ff;
   logic [3:0]              g_ff;
   logic [31:0]             n_ff;
   logic signed [VW-1:0]    v_ff [4];
   logic signed [VW-1:0]    l1_ff, l2_ff, ov_ff;
   logic [16:0]             amp_ff;
   logic signed [63:0]      total_ff;
   logic [4:0]              oct_ff, nmax_ff;
   logic signed [PW-1:0]    prod_ff, prod_in;
   logic signed [AW-1:0]    mul_a;
   logic signed [BW-1:0]    mul_b;
   logic                    rsp_valid_ff;
   logic signed [21:0]      rsp_value_ff;

   logic signed [63:0]      ix_c, iy_c, fxw_c, fyw_c;
   logic signed [63:0]      scaled_c;
   logic [3:0]              gsel_c;
   logic [31:0]             nnext_c;
   logic signed [31:0]      h_c;
   logic signed [VW-1:0]    vacc_c [4];
   logic signed [VW-1:0]    lerp_c;
   logic signed [VW-1:0]    lerp_base_c;
   logic signed [63:0]      res_c;
   logic signed [21:0]      res_sat_c;
   logic [16:0]             amp_next_c;
   logic [4:0]              nmax_c;

   function automatic logic [31:0] hash_n(input logic [31:0] x0, input logic [31:0] y0,
                                          input logic [3:0] g);
      logic [31:0] x, y, n0;
      x  = x0 + 32'(g[1:0]) - 32'd1;
      y  = y0 + 32'(g[3:2]) - 32'd1;
      n0 = x + (y << 6) - (y << 3) + y;
      return (n0 << 13) ^ n0;
   endfunction

   function automatic logic signed [63:0] trunc_div(input logic signed [63:0] v);
      logic signed [63:0] t;
      t = v[63] ? v + 64'((64'd1 << F) - 64'd1) : v;
      return t >>> F;
   endfunction

   assign csr_ready       = 1'b1;
   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_noise_value = rsp_value_ff;

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_SCALE_X: begin
            mul_a = AW'(cx_ff);
            mul_b = BW'({1'b0, invf_ff});
         end
         ST_SCALE_Y: begin
            mul_a = AW'(cy_ff);
            mul_b = BW'({1'b0, invf_ff});
         end
         ST_H1: begin
            mul_a = AW'({1'b0, n_ff});
            mul_b = BW'({1'b0, n_ff});
         end
         ST_H2: begin
            mul_a = AW'({1'b0, prod_ff[31:0]});
            mul_b = BW'({1'b0, fvn2d_pkg::HASH_C1});
         end
         ST_H3: begin
            mul_a = AW'({1'b0, n_ff});
            mul_b = BW'({1'b0, prod_ff[31:0] + fvn2d_pkg::HASH_C2});
         end
         ST_L0: begin
            mul_a = v_ff[1] - v_ff[0];
            mul_b = BW'(fx_ff);
         end
         ST_L1: begin
            mul_a = v_ff[3] - v_ff[2];
            mul_b = BW'(fx_ff);
         end
         ST_L3: begin
            mul_a = l2_ff - l1_ff;
            mul_b = BW'(fy_ff);
         end
         ST_L5: begin
            mul_a = ov_ff;
            mul_b = BW'({1'b0, amp_ff});
         end
         ST_L6: begin
            mul_a = AW'({1'b0, amp_ff});
            mul_b = BW'({1'b0, pers_ff});
         end
         default: begin
         end
      endcase
      prod_in = PW'(mul_a) * PW'(mul_b);
   end

   // lattice split, hash finish, smoothing accumulate, interpolation, output
   always_comb begin
      logic signed [PW-1:0] s;
      logic signed [63:0]   t;
      logic [31:0]          m;
      int                   cxp, cyp, ga, gb;
      ix_c     = trunc_div(px_ff);
      iy_c     = trunc_div(py_ff);
      fxw_c    = px_ff - (ix_c <<< F);
      fyw_c    = py_ff - (iy_c <<< F);
      s        = prod_ff[PW-1] ? prod_ff + LERP_RND : prod_ff;
      scaled_c = 64'(s >>> F);
      gsel_c   = (state_ff == ST_H0) ? g_ff : g_ff + 4'd1;
      nnext_c  = hash_n(lx_ff, ly_ff, gsel_c);
      m        = (prod_ff[31:0] + fvn2d_pkg::HASH_C3) & fvn2d_pkg::HASH_MASK;
      h_c      = $signed(fvn2d_pkg::HASH_ONE - m);
      ga       = int'(g_ff[1:0]);
      gb       = int'(g_ff[3:2]);
      for (int k = 0; k < 4; k++) begin
         cxp = 1 + (k % 2);
         cyp = 1 + (k / 2);
         vacc_c[k] = v_ff[k];
         if (ga >= cxp - 1 && ga <= cxp + 1 && gb >= cyp - 1 && gb <= cyp + 1) begin
            vacc_c[k] = v_ff[k] + (VW'(h_c) <<< (int'(ga == cxp) + int'(gb == cyp)));
         end
      end
      case (state_ff)
         ST_L1:   lerp_base_c = v_ff[0];
         ST_L2:   lerp_base_c = v_ff[2];
         default: lerp_base_c = l1_ff;
      endcase
      s      = (PW'(lerp_base_c) <<< F) + prod_ff;
      s      = s[PW-1] ? s + LERP_RND : s;
      lerp_c = VW'(s >>> F);
      t      = total_ff[63] ? total_ff + SUM_RND : total_ff;
      res_c  = t >>> SH;
      if (res_c > 64'sd1048576) begin
         res_sat_c = 22'(fvn2d_pkg::OUT_MAX);
      end else if (res_c < -64'sd1048576) begin
         res_sat_c = -22'(fvn2d_pkg::OUT_MAX);
      end else begin
         res_sat_c = res_c[21:0];
      end
      amp_next_c = (prod_ff[PW-1:16] > (PW-16)'(fvn2d_pkg::AMP_MAX)) ? fvn2d_pkg::AMP_MAX
                                                                    : prod_ff[32:16];
      nmax_c = (octs_ff > 5'(MAX_OCTAVES)) ? 5'(MAX_OCTAVES) : octs_ff;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pers_ff      <= fvn2d_pkg::PERSISTENCE_RST;
         octs_ff      <= fvn2d_pkg::OCTAVE_COUNT_RST;
         invf_ff      <= fvn2d_pkg::INV_FREQ_RST;
         oct_ff       <= '0;
         nmax_ff      <= '0;
         g_ff         <= '0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               fvn2d_pkg::CSR_PERSISTENCE:  pers_ff <= csr_wdata[16:0];
               fvn2d_pkg::CSR_OCTAVE_COUNT: octs_ff <= csr_wdata[4:0];
               fvn2d_pkg::CSR_INV_FREQ:     invf_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_FIN) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  cx_ff    <= req_coord_x;
                  cy_ff    <= req_coord_y;
                  total_ff <= '0;
                  amp_ff   <= fvn2d_pkg::AMP_START;
                  oct_ff   <= '0;
                  nmax_ff  <= nmax_c;
                  state_ff <= ST_SCALE_X;
               end
            end
            ST_SCALE_X: state_ff <= ST_SCALE_Y;
            ST_SCALE_Y: begin
               px_ff    <= scaled_c;
               state_ff <= ST_SCALE_END;
            end
            ST_SCALE_END: begin
               py_ff    <= scaled_c;
               state_ff <= (nmax_ff == 5'd0) ? ST_FIN : ST_OCT;
            end
            ST_OCT: begin
               lx_ff <= ix_c[31:0];
               ly_ff <= iy_c[31:0];
               fx_ff <= fxw_c[F:0];
               fy_ff <= fyw_c[F:0];
               for (int k = 0; k < 4; k++) begin
                  v_ff[k] <= '0;
               end
               g_ff     <= '0;
               state_ff <= ST_H0;
            end
            ST_H0: begin
               n_ff     <= nnext_c;
               state_ff <= ST_H1;
            end
            ST_H1: state_ff <= ST_H2;
            ST_H2: state_ff <= ST_H3;
            ST_H3: state_ff <= ST_HACC;
            ST_HACC: begin
               for (int k = 0; k < 4; k++) begin
                  v_ff[k] <= vacc_c[k];
               end
               if (g_ff == 4'd15) begin
                  state_ff <= ST_L0;
               end else begin
                  g_ff     <= g_ff + 4'd1;
                  n_ff     <= nnext_c;
                  state_ff <= ST_H1;
               end
            end
            ST_L0: state_ff <= ST_L1;
            ST_L1: begin
               l1_ff    <= lerp_c;
               state_ff <= ST_L2;
            end
            ST_L2: begin
               l2_ff    <= lerp_c;
               state_ff <= ST_L3;
            end
            ST_L3: state_ff <= ST_L4;
            ST_L4: begin
               ov_ff    <= lerp_c;
               state_ff <= ST_L5;
            end
            ST_L5: state_ff <= ST_L6;
            ST_L6: begin
               total_ff <= total_ff + prod_ff[63:0];
               state_ff <= ST_L7;
            end
            ST_L7: begin
               amp_ff   <= amp_next_c;
               px_ff    <= px_ff <<< 1;
               py_ff    <= py_ff <<< 1;
               oct_ff   <= oct_ff + 5'd1;
               state_ff <= (oct_ff + 5'd1 == nmax_ff) ? ST_FIN : ST_OCT;
            end
            ST_FIN: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_value_ff <= res_sat_c;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   `FVN_ASSERT_IMPLIES(a_busy_stall, clock, reset, state_ff != ST_IDLE, req_stall)
   `FVN_ASSERT_IMPLIES(a_rsp_range, clock, reset, rsp_valid, (rsp_noise_value <= 22'sd1048576) && (rsp_noise_value >= -22'sd1048576))
   `FVN_ASSERT_NEXT(a_accept_start, clock, reset, req_valid && !req_stall, state_ff == ST_SCALE_X)
   `FVN_ASSERT_IMPLIES(a_oct_bound, clock, reset, state_ff == ST_OCT, oct_ff < nmax_ff)

endmodule
